// ----- hw/rtl/lsos_pkg.sv -----
// ----------------------------------------------------------------------------
// lsos_pkg
// Shared types and constants for the lidar sector obstacle scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsos_pkg;

    localparam logic [19:0] EMPTY_MM     = 20'd999000;
    localparam logic [11:0] FULL_CIRCLE  = 12'd3600;
    localparam logic [15:0] NO_SIGNAL_MM = 16'd2000;
    localparam logic [15:0] TOUCH_MM     = 16'd10;

    localparam int          DIV_STEPS    = 16;
    localparam int          CNT_W        = $clog2(DIV_STEPS);

    localparam logic [10:0] RST_FRONT_HALF  = 11'd300;
    localparam logic [10:0] RST_SIDE_START  = 11'd300;
    localparam logic [10:0] RST_SIDE_END    = 11'd900;
    localparam logic [14:0] RST_STOP_DIST   = 15'd300;
    localparam logic [14:0] RST_SLOW_DIST   = 15'd1000;
    localparam logic [15:0] RST_STEER_CTR   = 16'sd0;
    localparam logic [15:0] RST_STEER_LEFT  = 16'hFC18;
    localparam logic [15:0] RST_STEER_RIGHT = 16'd1000;

    typedef logic [3:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FRONT_HALF  = 4'd0;
    localparam t_cfg_idx CFG_SIDE_START  = 4'd1;
    localparam t_cfg_idx CFG_SIDE_END    = 4'd2;
    localparam t_cfg_idx CFG_STOP_DIST   = 4'd3;
    localparam t_cfg_idx CFG_SLOW_DIST   = 4'd4;
    localparam t_cfg_idx CFG_STEER_CTR   = 4'd5;
    localparam t_cfg_idx CFG_STEER_LEFT  = 4'd6;
    localparam t_cfg_idx CFG_STEER_RIGHT = 4'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic item_load;
        logic div_step;
        logic mul_load;
        logic fin_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic steer_req;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/lsos_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsos_ctrl
// Sequencer: point intake, steering division, multiply, finish, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lsos_ctrl import lsos_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire      i_scan_end,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_scan_end) begin
                    n_state = i_stat.steer_req ? S_DIV : S_OUT;
                end
            end
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.item_load = i_in_valid;
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_MUL:  o_cmd.mul_load = 1'b1;
            S_FIN:  o_cmd.fin_load = 1'b1;
            S_OUT:  o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lsos_dp.sv -----
// ----------------------------------------------------------------------------
// lsos_dp
// Datapath: settings, sector minima, restoring divider, steering math, output.
// ----------------------------------------------------------------------------
`default_nettype none

module lsos_dp import lsos_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [3:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data,
    input  wire  [11:0]       i_angle_tenths,
    input  wire signed [15:0] i_distance_mm,
    input  wire               i_scan_end,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [19:0]       o_front_nearest,
    output logic [19:0]       o_left_nearest,
    output logic [19:0]       o_right_nearest,
    output logic              o_emergency_stop,
    output logic              o_steer_valid,
    output logic signed [15:0] o_steer_value
);

    logic [10:0] r_front_half;
    logic [10:0] r_side_start;
    logic [10:0] r_side_end;
    logic [14:0] r_stop_dist;
    logic [14:0] r_slow_dist;
    logic signed [15:0] r_steer_ctr;
    logic signed [15:0] r_steer_left;
    logic signed [15:0] r_steer_right;

    logic [19:0] r_front_run;
    logic [19:0] r_left_run;
    logic [19:0] r_right_run;
    logic [19:0] n_front_run;
    logic [19:0] n_left_run;
    logic [19:0] n_right_run;

    logic [19:0] r_snap_front;
    logic [19:0] r_snap_left;
    logic [19:0] r_snap_right;
    logic        r_snap_emerg;
    logic        r_snap_steer;
    logic        r_go_left;

    logic [14:0]       r_rem;
    logic [15:0]       r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic signed [34:0] r_prod;
    logic signed [15:0] r_steer;
    logic              r_out_valid;

    logic [15:0] clean_d;
    logic [19:0] dist20;
    logic [11:0] fr_lo;
    logic [11:0] rt_lo;
    logic [11:0] rt_hi;
    logic [11:0] lt_lo;
    logic [11:0] lt_hi;
    logic        hit_front;
    logic        hit_left;
    logic        hit_right;
    logic        n_emerg;
    logic        n_steer;

    logic [15:0] rem2;
    logic        q_bit;
    logic [16:0] urgency;
    logic signed [16:0] delta;
    logic signed [35:0] sum;
    logic signed [19:0] shr;
    logic signed [19:0] trunc_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_half  <= RST_FRONT_HALF;
            r_side_start  <= RST_SIDE_START;
            r_side_end    <= RST_SIDE_END;
            r_stop_dist   <= RST_STOP_DIST;
            r_slow_dist   <= RST_SLOW_DIST;
            r_steer_ctr   <= RST_STEER_CTR;
            r_steer_left  <= RST_STEER_LEFT;
            r_steer_right <= RST_STEER_RIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRONT_HALF:  r_front_half  <= i_cfg_data[10:0];
                CFG_SIDE_START:  r_side_start  <= i_cfg_data[10:0];
                CFG_SIDE_END:    r_side_end    <= i_cfg_data[10:0];
                CFG_STOP_DIST:   r_stop_dist   <= i_cfg_data[14:0];
                CFG_SLOW_DIST:   r_slow_dist   <= i_cfg_data[14:0];
                CFG_STEER_CTR:   r_steer_ctr   <= i_cfg_data;
                CFG_STEER_LEFT:  r_steer_left  <= i_cfg_data;
                CFG_STEER_RIGHT: r_steer_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (i_distance_mm < 16'sd0) begin
            clean_d = TOUCH_MM;
        end else if (i_distance_mm == 16'sd0) begin
            clean_d = NO_SIGNAL_MM;
        end else begin
            clean_d = i_distance_mm;
        end
        dist20 = {4'd0, clean_d};

        fr_lo = FULL_CIRCLE - {1'b0, r_front_half};
        lt_lo = {1'b0, r_side_start};
        lt_hi = {1'b0, r_side_end};
        rt_lo = FULL_CIRCLE - {1'b0, r_side_end};
        rt_hi = FULL_CIRCLE - {1'b0, r_side_start};

        hit_front = (i_angle_tenths <= {1'b0, r_front_half})
                 || (i_angle_tenths >= fr_lo && i_angle_tenths <= FULL_CIRCLE);
        hit_left  = (lt_lo <= lt_hi)
                  ? (i_angle_tenths >= lt_lo && i_angle_tenths <= lt_hi)
                  : (i_angle_tenths >= lt_lo || i_angle_tenths <= lt_hi);
        hit_right = (rt_lo <= rt_hi)
                  ? (i_angle_tenths >= rt_lo && i_angle_tenths <= rt_hi)
                  : (i_angle_tenths >= rt_lo || i_angle_tenths <= rt_hi);

        n_front_run = (hit_front && dist20 < r_front_run) ? dist20 : r_front_run;
        n_left_run  = (hit_left  && dist20 < r_left_run)  ? dist20 : r_left_run;
        n_right_run = (hit_right && dist20 < r_right_run) ? dist20 : r_right_run;

        n_emerg = n_front_run < {5'd0, r_stop_dist};
        n_steer = (n_front_run < {5'd0, r_slow_dist}) && !n_emerg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_run <= EMPTY_MM;
            r_left_run  <= EMPTY_MM;
            r_right_run <= EMPTY_MM;
        end else if (i_cmd.item_load) begin
            if (i_scan_end) begin
                r_front_run <= EMPTY_MM;
                r_left_run  <= EMPTY_MM;
                r_right_run <= EMPTY_MM;
            end else begin
                r_front_run <= n_front_run;
                r_left_run  <= n_left_run;
                r_right_run <= n_right_run;
            end
        end
    end

    always_comb begin
        rem2    = {r_rem, 1'b0};
        q_bit   = rem2 >= {1'b0, r_slow_dist};
        urgency = 17'h10000 - {1'b0, r_quo};
        delta   = r_go_left
                ? ({r_steer_left[15], r_steer_left} - {r_steer_ctr[15], r_steer_ctr})
                : ({r_steer_right[15], r_steer_right} - {r_steer_ctr[15], r_steer_ctr});
        sum     = {{4{r_steer_ctr[15]}}, r_steer_ctr, 16'd0}
                + {r_prod[34], r_prod};
        shr     = sum[35:16];
        trunc_q = shr + {19'd0, (sum[35] && (sum[15:0] != 16'd0))};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load && i_scan_end) begin
            r_snap_front <= n_front_run;
            r_snap_left  <= n_left_run;
            r_snap_right <= n_right_run;
            r_snap_emerg <= n_emerg;
            r_snap_steer <= n_steer;
            r_go_left    <= n_left_run > n_right_run;
            r_rem        <= n_front_run[14:0];
            r_quo        <= '0;
            r_cnt        <= CNT_W'(DIV_STEPS - 1);
            r_steer      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? 15'(rem2 - {1'b0, r_slow_dist}) : rem2[14:0];
            r_quo <= {r_quo[14:0], q_bit};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul_load) begin
            r_prod <= $signed({1'b0, urgency}) * delta;
        end
        if (i_cmd.fin_load) begin
            priority if (trunc_q > 20'sd32767) begin
                r_steer <= 16'sh7FFF;
            end else if (trunc_q < -20'sd32768) begin
                r_steer <= 16'sh8000;
            end else begin
                r_steer <= trunc_q[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_front_nearest  <= r_snap_front;
            o_left_nearest   <= r_snap_left;
            o_right_nearest  <= r_snap_right;
            o_emergency_stop <= r_snap_emerg;
            o_steer_valid    <= r_snap_steer;
            o_steer_value    <= r_steer;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.steer_req = n_steer;
    assign o_stat.div_last  = (r_cnt == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_sector_obstacle_scan.sv -----
// ----------------------------------------------------------------------------
// lidar_sector_obstacle_scan
// Nearest-obstacle scan over front, left and right lidar sectors.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle while a scan is in progress.
// Scan end: without steering, the result is registered at the output once the output is free;
//   with steering, it first passes the restoring divider (one quotient bit a cycle), multiply and finish.
// Input is held off from the scan-end transfer until the result is registered.
// Reset (synchronous, active low): settings to defaults, minima to 999000,
//   controller idle, no result pending.
`default_nettype none

module lidar_sector_obstacle_scan import lsos_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [3:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [11:0]       i_angle_tenths,
    input  wire signed [15:0] i_distance_mm,
    input  wire               i_scan_end,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [19:0]       o_front_nearest,
    output logic [19:0]       o_left_nearest,
    output logic [19:0]       o_right_nearest,
    output logic              o_emergency_stop,
    output logic              o_steer_valid,
    output logic signed [15:0] o_steer_value
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lsos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_scan_end (i_scan_end),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lsos_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_angle_tenths   (i_angle_tenths),
        .i_distance_mm    (i_distance_mm),
        .i_scan_end       (i_scan_end),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_front_nearest  (o_front_nearest),
        .o_left_nearest   (o_left_nearest),
        .o_right_nearest  (o_right_nearest),
        .o_emergency_stop (o_emergency_stop),
        .o_steer_valid    (o_steer_valid),
        .o_steer_value    (o_steer_value)
    );

    a_busy_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_scan_end |=> !o_in_ready)
        else $error("input still open after scan-end transfer");

    a_steer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_steer_valid |-> o_steer_value == 16'sd0)
        else $error("steering value set without suggestion");

    a_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_emergency_stop && o_steer_valid))
        else $error("emergency and steering both flagged");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.item_load, cmd.div_step, cmd.mul_load, cmd.fin_load, cmd.out_load}))
        else $error("overlapping datapath commands");

endmodule

`default_nettype wire
